[rtl/cagc_pkg.sv]
// shared types, constants and helpers for the cochlear agc smoothing loop
// no dependencies

package cagc_pkg;

	localparam int MAX_CHANNELS = 128;
	localparam int MAX_MICS     = 2;
	localparam int MAX_STAGES   = 4;
	localparam int WARMUP_SPAN  = 10;

	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int CNT_W   = CH_W + 1;
	localparam int MIC_W   = 1;
	localparam int STG_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int DET_AW  = MIC_W + CH_W;
	localparam int SMEM_AW = MIC_W + STG_W + CH_W;
	localparam int XS_AW   = 1 + CH_W;

	localparam int DW     = 24;
	localparam int DXW    = DW + 1;
	localparam int XW     = DW + 1;
	localparam int KW     = 17;
	localparam int PROD_W = DXW + KW + 1;
	localparam int WIDE_W = PROD_W + 1;
	localparam int CFG_W  = 48;
	localparam int REG_W  = 3;
	localparam int CHAN_REG_W = 8;
	localparam int MIC_REG_W  = 2;
	localparam int STG_REG_W  = 3;

	localparam int COEF_FRAC = 16;
	localparam int GAIN_FRAC = 12;
	localparam logic [KW-1:0] K_ONE = KW'(1 << COEF_FRAC);

	typedef logic signed [DW-1:0] data_t;
	typedef logic signed [XW-1:0] xsum_t;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [REG_W-1:0] {
		REG_COEF0    = 3'd0,
		REG_COEF1    = 3'd1,
		REG_COEF2    = 3'd2,
		REG_COEF3    = 3'd3,
		REG_GAINS    = 3'd4,
		REG_CHANNELS = 3'd5,
		REG_MICS     = 3'd6,
		REG_STAGES   = 3'd7
	} reg_idx_t;

	localparam logic REPLY_ACK  = 1'b0;
	localparam logic REPLY_DATA = 1'b1;

	typedef enum logic [1:0] {
		PASS_WARM,
		PASS_BACK,
		PASS_FWD
	} pass_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_A_RD,
		ST_A_X,
		ST_A_G,
		ST_A_RDC,
		ST_A_E,
		ST_A_WR,
		ST_S_RD,
		ST_S_OP,
		ST_S_UPD,
		ST_C_RD,
		ST_C_WR,
		ST_DONE,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [MIC_W-1:0] mic;
		logic [CH_W-1:0]  channel;
		data_t            detect_value;
	} in_item_t;

	typedef struct packed {
		logic  reply_kind;
		data_t gain_sum;
	} out_item_t;

	typedef struct packed {
		logic          go;
		logic          toward;
		data_t         base;
		data_t         target;
		logic [KW-1:0] k;
	} alu_req_t;

	typedef struct packed {
		logic               det_we;
		logic [DET_AW-1:0]  det_waddr;
		data_t              det_wdata;
		logic [DET_AW-1:0]  det_raddr;
		logic               smem_we;
		logic [SMEM_AW-1:0] smem_addr;
		data_t              smem_wdata;
		logic               gsum_we;
		logic [DET_AW-1:0]  gsum_addr;
		data_t              gsum_wdata;
		logic               xsum_we;
		logic [XS_AW-1:0]   xsum_addr;
		xsum_t              xsum_wdata;
	} mem_req_t;

	function automatic data_t sat_data(input logic signed [WIDE_W-1:0] v);
		data_t r;
		if (v[WIDE_W-1:DW-1] == '0 || v[WIDE_W-1:DW-1] == '1) begin
			r = v[DW-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r = {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[rtl/cagc_alu.sv]
// shared multiply, round, add and saturate unit; the product is registered, then the saturated result
// depends on cagc_pkg

module cagc_alu import cagc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output data_t    res
);

	logic signed [DXW-1:0]    opnd;
	logic signed [PROD_W-1:0] prod_s1;
	data_t                    base_s1;
	logic                     sh16_s1;
	logic                     v_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] shf;
	logic signed [WIDE_W-1:0] total;
	data_t                    res_q;

	// toward: base + round(k * (target - base)), otherwise round(k * target)
	assign opnd = req.toward ? (DXW'(req.target) - DXW'(req.base)) : DXW'(req.target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.go;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			prod_s1 <= opnd * $signed({1'b0, req.k});
			base_s1 <= req.toward ? req.base : '0;
			sh16_s1 <= req.toward;
		end
		if (v_s1) begin
			res_q <= sat_data(total);
		end
	end

	always_comb begin
		rnd   = sh16_s1 ? (prod_s1 + (PROD_W'(1) <<< (COEF_FRAC - 1)))
		                : (prod_s1 + (PROD_W'(1) <<< (GAIN_FRAC - 1)));
		shf   = sh16_s1 ? (rnd >>> COEF_FRAC) : (rnd >>> GAIN_FRAC);
		total = WIDE_W'(shf) + WIDE_W'(base_s1);
	end

	assign res = res_q;

endmodule

[rtl/cagc_store.sv]
// detect, stage memory, gain sum and cross-mic sum memories, registered reads
// depends on cagc_pkg

module cagc_store import cagc_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output data_t    det_rd,
	output data_t    smem_rd,
	output data_t    gsum_rd,
	output xsum_t    xsum_rd
);

	data_t det_mem  [2**DET_AW];
	data_t smem_mem [2**SMEM_AW];
	data_t gsum_mem [2**DET_AW];
	xsum_t xsum_mem [2**XS_AW];

	data_t det_rd_q;
	data_t smem_rd_q;
	data_t gsum_rd_q;
	xsum_t xsum_rd_q;

	always_ff @(posedge clk) begin
		if (req.det_we) begin
			det_mem[req.det_waddr] <= req.det_wdata;
		end
		det_rd_q <= det_mem[req.det_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.smem_we) begin
			smem_mem[req.smem_addr] <= req.smem_wdata;
		end
		smem_rd_q <= smem_mem[req.smem_addr];
	end

	always_ff @(posedge clk) begin
		if (req.gsum_we) begin
			gsum_mem[req.gsum_addr] <= req.gsum_wdata;
		end
		gsum_rd_q <= gsum_mem[req.gsum_addr];
	end

	always_ff @(posedge clk) begin
		if (req.xsum_we) begin
			xsum_mem[req.xsum_addr] <= req.xsum_wdata;
		end
		xsum_rd_q <= xsum_mem[req.xsum_addr];
	end

	assign det_rd  = det_rd_q;
	assign smem_rd = smem_rd_q;
	assign gsum_rd = gsum_rd_q;
	assign xsum_rd = xsum_rd_q;

endmodule

[rtl/cochlear_agc_smoothing_loop.sv]
// top level of the cochlear agc smoothing loop: config registers, sequencer, result register
// depends on cagc_pkg, cagc_alu, cagc_store

// After reset the block clears its stage memories and gain sums, one entry a cycle, and
// takes no request until it is done. A detect load is written to the detect memory as it is
// transferred; a read returns the gain sum through the registered memory read and the
// result register. An update runs through one shared multiply-round-saturate unit and the
// single port of the stage memory: per stage and mic it runs the input step, a warm-up
// pass over the last min(n,10) channels, a backward and a forward smoothing pass and the
// gain sums, n being the channel count.

module cochlear_agc_smoothing_loop import cagc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  in_item_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output out_item_t        rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0]      coef_q [MAX_STAGES];
	logic [CFG_W-1:0]      gains_q;
	logic [CHAN_REG_W-1:0] chans_q;
	logic [MIC_REG_W-1:0]  mics_q;
	logic [STG_REG_W-1:0]  stages_q;

	state_t               state_q, state_d, ret_q, ret_d;
	pass_t                pass_q, pass_d;
	logic [STG_W-1:0]     s_q, s_d;
	logic [MIC_W-1:0]     m_q, m_d;
	logic [CH_W-1:0]      ch_q, ch_d;
	data_t                st_q, st_d;
	logic [SMEM_AW-1:0]   clr_q, clr_d;
	logic                 rsp_valid_q;
	out_item_t            rsp_q;
	logic                 rsp_load;
	out_item_t            rsp_new;

	logic [CNT_W-1:0]     nch;
	logic [CH_W-1:0]      ch_last;
	logic [CH_W-1:0]      warm_start;
	logic [MIC_W-1:0]     nmic_m1;
	logic [STG_W-1:0]     nst_m1;
	logic                 mono;
	logic [CFG_W-1:0]     coef;
	logic [KW-1:0]        eps, k1, k2, dscale, sgain, mix;
	data_t                mean;
	logic                 req_xfer;

	alu_req_t             alu_req;
	data_t                alu_res;
	mem_req_t             mem_req;
	data_t                det_rd, smem_rd, gsum_rd;
	xsum_t                xsum_rd;

	cagc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.res    (alu_res)
	);

	cagc_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.det_rd  (det_rd),
		.smem_rd (smem_rd),
		.gsum_rd (gsum_rd),
		.xsum_rd (xsum_rd)
	);

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STAGES; i++) begin
				coef_q[i] <= '0;
			end
			gains_q  <= '0;
			chans_q  <= CHAN_REG_W'(96);
			mics_q   <= MIC_REG_W'(2);
			stages_q <= STG_REG_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: begin
					coef_q[cfg_index[STG_W-1:0]] <= cfg_data;
				end
				REG_GAINS:    gains_q  <= cfg_data;
				REG_CHANNELS: chans_q  <= cfg_data[CHAN_REG_W-1:0];
				REG_MICS:     mics_q   <= cfg_data[MIC_REG_W-1:0];
				REG_STAGES:   stages_q <= cfg_data[STG_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// derived loop limits and coefficients
	always_comb begin
		nch        = (CNT_W'(chans_q) > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
		                                                       : CNT_W'(chans_q);
		ch_last    = CH_W'(nch - CNT_W'(1));
		warm_start = (nch > CNT_W'(WARMUP_SPAN)) ? CH_W'(nch - CNT_W'(WARMUP_SPAN)) : '0;
		nmic_m1    = (mics_q >= MIC_REG_W'(MAX_MICS)) ? MIC_W'(MAX_MICS - 1) : '0;
		if (stages_q == '0) begin
			nst_m1 = '0;
		end else if (stages_q > STG_REG_W'(MAX_STAGES)) begin
			nst_m1 = STG_W'(MAX_STAGES - 1);
		end else begin
			nst_m1 = STG_W'(stages_q - STG_REG_W'(1));
		end
		mono   = (nmic_m1 == '0);
		coef   = coef_q[s_q];
		eps    = {1'b0, coef[15:0]};
		k1     = K_ONE - {1'b0, coef[31:16]};
		k2     = K_ONE - {1'b0, coef[47:32]};
		dscale = {1'b0, gains_q[15:0]};
		sgain  = {1'b0, gains_q[31:16]};
		mix    = {1'b0, gains_q[47:32]};
		mean   = xsum_rd[XW-1:1];
	end

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_xfer  = req_valid && req_ready;

	// sequencer
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		pass_d   = pass_q;
		s_d      = s_q;
		m_d      = m_q;
		ch_d     = ch_q;
		st_d     = st_q;
		clr_d    = clr_q;
		rsp_load = 1'b0;
		rsp_new  = '{reply_kind: REPLY_ACK, gain_sum: '0};

		alu_req  = '{go: 1'b0, toward: 1'b1, base: st_q, target: smem_rd, k: k1};

		mem_req            = '0;
		mem_req.det_waddr  = {req.mic, req.channel};
		mem_req.det_wdata  = req.detect_value;
		mem_req.det_raddr  = {m_q, ch_q};
		mem_req.smem_addr  = {m_q, s_q, ch_q};
		mem_req.smem_wdata = alu_res;
		mem_req.gsum_addr  = {m_q, ch_q};
		mem_req.gsum_wdata = (s_q == '0) ? smem_rd
		                     : sat_data(WIDE_W'(gsum_rd) + WIDE_W'(smem_rd));
		mem_req.xsum_addr  = {s_q[0], ch_q};
		mem_req.xsum_wdata = (m_q == '0) ? XW'(smem_rd) : (xsum_rd + XW'(smem_rd));

		unique case (state_q)
			ST_CLEAR: begin
				mem_req.smem_addr  = clr_q;
				mem_req.smem_we    = 1'b1;
				mem_req.smem_wdata = '0;
				mem_req.gsum_addr  = clr_q[DET_AW-1:0];
				mem_req.gsum_we    = 1'b1;
				mem_req.gsum_wdata = '0;
				clr_d = clr_q + SMEM_AW'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				mem_req.gsum_addr = {req.mic, req.channel};
				if (req_xfer) begin
					unique case (req.cmd)
						CMD_LOAD: begin
							mem_req.det_we = 1'b1;
						end
						CMD_UPDATE: begin
							s_d  = '0;
							m_d  = '0;
							ch_d = '0;
							state_d = (nch == '0) ? ST_DONE : ST_A_RD;
						end
						CMD_READ: begin
							state_d = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				rsp_load = 1'b1;
				rsp_new  = '{reply_kind: REPLY_DATA, gain_sum: gsum_rd};
				state_d  = ST_IDLE;
			end
			ST_A_RD: begin
				mem_req.smem_addr = {m_q, STG_W'(s_q - STG_W'(1)), ch_q};
				mem_req.xsum_addr = {~s_q[0], ch_q};
				state_d = ST_A_X;
			end
			ST_A_X: begin
				alu_req.go = 1'b1;
				state_d    = ST_WAIT;
				if (s_q == '0) begin
					alu_req.toward = 1'b0;
					alu_req.target = det_rd;
					alu_req.k      = dscale;
					ret_d = ST_A_RDC;
				end else if (mono) begin
					alu_req.toward = 1'b0;
					alu_req.target = smem_rd;
					alu_req.k      = sgain;
					ret_d = ST_A_RDC;
				end else begin
					alu_req.base   = smem_rd;
					alu_req.target = mean;
					alu_req.k      = mix;
					ret_d = ST_A_G;
				end
			end
			ST_A_G: begin
				alu_req.go     = 1'b1;
				alu_req.toward = 1'b0;
				alu_req.target = alu_res;
				alu_req.k      = sgain;
				ret_d   = ST_A_RDC;
				state_d = ST_WAIT;
			end
			ST_A_RDC: begin
				state_d = ST_A_E;
			end
			ST_A_E: begin
				alu_req.go     = 1'b1;
				alu_req.base   = smem_rd;
				alu_req.target = alu_res;
				alu_req.k      = eps;
				ret_d   = ST_A_WR;
				state_d = ST_WAIT;
			end
			ST_A_WR: begin
				mem_req.smem_we = 1'b1;
				if (ch_q == ch_last) begin
					pass_d  = PASS_WARM;
					ch_d    = warm_start;
					st_d    = '0;
					state_d = ST_S_RD;
				end else begin
					ch_d    = ch_q + CH_W'(1);
					state_d = ST_A_RD;
				end
			end
			ST_S_RD: begin
				state_d = ST_S_OP;
			end
			ST_S_OP: begin
				alu_req.go = 1'b1;
				alu_req.k  = (pass_q == PASS_BACK) ? k2 : k1;
				ret_d   = ST_S_UPD;
				state_d = ST_WAIT;
			end
			ST_S_UPD: begin
				st_d    = alu_res;
				state_d = ST_S_RD;
				case (pass_q)
					PASS_WARM: begin
						if (ch_q == ch_last) begin
							pass_d = PASS_BACK;
						end else begin
							ch_d = ch_q + CH_W'(1);
						end
					end
					PASS_BACK: begin
						mem_req.smem_we = 1'b1;
						if (ch_q == '0) begin
							pass_d = PASS_FWD;
						end else begin
							ch_d = ch_q - CH_W'(1);
						end
					end
					default: begin
						mem_req.smem_we = 1'b1;
						if (ch_q == ch_last) begin
							ch_d    = '0;
							state_d = ST_C_RD;
						end else begin
							ch_d = ch_q + CH_W'(1);
						end
					end
				endcase
			end
			ST_C_RD: begin
				state_d = ST_C_WR;
			end
			ST_C_WR: begin
				mem_req.gsum_we = 1'b1;
				mem_req.xsum_we = !mono;
				if (ch_q == ch_last) begin
					ch_d = '0;
					if (m_q == nmic_m1) begin
						m_d = '0;
						if (s_q == nst_m1) begin
							state_d = ST_DONE;
						end else begin
							s_d     = s_q + STG_W'(1);
							state_d = ST_A_RD;
						end
					end else begin
						m_d     = m_q + MIC_W'(1);
						state_d = ST_A_RD;
					end
				end else begin
					ch_d    = ch_q + CH_W'(1);
					state_d = ST_C_RD;
				end
			end
			ST_DONE: begin
				rsp_load = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_WAIT: begin
				state_d = ret_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= ST_IDLE;
			pass_q  <= PASS_WARM;
			s_q     <= '0;
			m_q     <= '0;
			ch_q    <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			pass_q  <= pass_d;
			s_q     <= s_d;
			m_q     <= m_d;
			ch_q    <= ch_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_new;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
